[hdl/first_fit_descriptor_allocator_macros.svh]
// Assertion macros used by the allocator module.
`ifndef FIRST_FIT_DESCRIPTOR_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_DESCRIPTOR_ALLOCATOR_MACROS_SVH

// Property that must hold whenever the antecedent holds in the same cycle.
`define FFDA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Property whose consequent is checked in the following cycle.
`define FFDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[hdl/ffda_pkg.sv]
`timescale 1ns / 1ps
package ffda_pkg;
	localparam int unsigned LEN_W = 21;
	localparam int unsigned IDX_W = 20;
	localparam int unsigned S_TDATA_W = ((2 + LEN_W + IDX_W + 7) / 8) * 8;
	localparam int unsigned M_TDATA_W = ((2 + IDX_W + 128 + 7) / 8) * 8;
	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE = 2'd1,
		OP_COALESCE = 2'd2,
		OP_RESET_BUMP = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_LIST_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_CAPACITY = 2'd0,
		REG_STRIDE = 2'd1,
		REG_CPU_BASE = 2'd2,
		REG_GPU_BASE = 2'd3
	} reg_index_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIND,
		S_FREE_POS,
		S_SORT,
		S_MERGE,
		S_MUL,
		S_OUT
	} state_t;

	// Commands from the controller to each cell of the free list.
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_SHIFT_UP,
		CMD_SHIFT_DOWN,
		CMD_WRITE,
		CMD_SWAP_PASS
	} cell_cmd_t;
endpackage

[hdl/ffda_cell.sv]
`timescale 1ns / 1ps
module ffda_cell import ffda_pkg::*; (
	input logic clk,
	input cell_cmd_t cmd,
	input logic sel,
	input logic [IDX_W-1:0] wr_start,
	input logic [LEN_W-1:0] wr_len,
	input logic [IDX_W-1:0] prev_start,
	input logic [LEN_W-1:0] prev_len,
	input logic [IDX_W-1:0] next_start,
	input logic [LEN_W-1:0] next_len,
	input logic take_prev,
	input logic take_next,
	output logic [IDX_W-1:0] start_q,
	output logic [LEN_W-1:0] len_q
);
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_SHIFT_DOWN: begin
				if (sel) begin
					start_q <= next_start;
					len_q <= next_len;
				end
			end
			CMD_SHIFT_UP: begin
				if (sel) begin
					start_q <= prev_start;
					len_q <= prev_len;
				end
			end
			CMD_WRITE: begin
				if (sel) begin
					start_q <= wr_start;
					len_q <= wr_len;
				end
			end
			CMD_SWAP_PASS: begin
				if (take_prev) begin
					start_q <= prev_start;
					len_q <= prev_len;
				end else if (take_next) begin
					start_q <= next_start;
					len_q <= next_len;
				end
			end
			default: begin
			end
		endcase
	end
endmodule

[hdl/first_fit_descriptor_allocator.sv]
`timescale 1ns / 1ps
// Allocate scans the free list until a block fits, else takes the bump pointer, and then
// multiplies the granted index by the stride; free scans for its sorted position; coalesce
// sorts, then merges; a bump reset, a full-list free or an empty coalesce goes to the result.
// Throughput: one beat in flight; the next beat is taken in the cycle after the result is loaded,
// and an operation waits in its last cycle while the previous result beat is not taken.
// Reset clears registers, bump pointer, block count and handshake state, not the cell row.
module first_fit_descriptor_allocator import ffda_pkg::*; #(
	parameter int unsigned MAX_FREE_BLOCKS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// tdata: opcode, slot_count, slot_offset, zero fill
	input logic [S_TDATA_W-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// tdata: status, slot_index, cpu_handle, gpu_handle, zero fill
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [63:0] cfg_data
);
	`include "first_fit_descriptor_allocator_macros.svh"

	localparam int unsigned N = MAX_FREE_BLOCKS;
	localparam int unsigned CW = $clog2(N + 1);
	localparam int unsigned PW = (N > 1) ? $clog2(N) : 1;
	localparam int unsigned MW = IDX_W + 13;

	logic [LEN_W-1:0] capacity_q;
	logic [12:0] stride_q;
	logic [63:0] cpu_base_q, gpu_base_q;

	logic [LEN_W-1:0] bump_q;
	logic [CW-1:0] count_q;
	state_t state_q, state_d;
	logic [CW-1:0] iter_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] merge_q;
	logic phase_q;
	opcode_t op_q;
	logic [LEN_W-1:0] req_cnt_q;
	logic [IDX_W-1:0] req_off_q;
	status_t status_q;
	logic [IDX_W-1:0] index_q;
	logic [MW-1:0] prod_q;
	logic out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;
	logic [M_TDATA_W-1:0] out_word;

	logic [IDX_W-1:0] c_start [N];
	logic [LEN_W-1:0] c_len [N];
	cell_cmd_t cell_cmd [N];
	logic [N-1:0] cell_sel, take_prev, take_next;
	logic [IDX_W-1:0] wr_start;
	logic [LEN_W-1:0] wr_len;

	logic in_beat, out_free;
	opcode_t in_op;
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_beat = s_axis_tvalid && s_axis_tready;
	assign in_op = opcode_t'(s_axis_tdata[1:0]);
	assign cfg_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	// Scan pointer for allocate and free.
	logic [PW-1:0] scan_idx;
	logic [IDX_W-1:0] scan_start;
	logic [LEN_W-1:0] scan_len, scan_rem;
	logic scan_end, scan_fits, scan_less;
	assign scan_idx = (iter_q < CW'(N)) ? PW'(iter_q) : '0;
	assign scan_start = c_start[scan_idx];
	assign scan_len = c_len[scan_idx];
	assign scan_end = (iter_q == count_q);
	assign scan_fits = scan_len >= req_cnt_q;
	assign scan_rem = scan_len - req_cnt_q;
	assign scan_less = (scan_start != req_off_q) ? (scan_start < req_off_q)
		: (scan_len < req_cnt_q);

	logic [LEN_W:0] bump_sum;
	logic bump_ok;
	assign bump_sum = {1'b0, bump_q} + {1'b0, req_cnt_q};
	assign bump_ok = (bump_sum <= {1'b0, capacity_q}) && (bump_q[LEN_W-1:IDX_W] == '0);

	// Merge: entry pos_q accumulates, entry merge_q is the candidate.
	logic [PW-1:0] acc_idx, cand_idx, nxt_idx;
	logic [LEN_W:0] end_full, len_sum;
	logic merge_end, adjacent;
	assign acc_idx = PW'(pos_q);
	assign nxt_idx = PW'(pos_q + CW'(1));
	assign cand_idx = (merge_q < CW'(N)) ? PW'(merge_q) : '0;
	assign end_full = {2'b0, c_start[acc_idx]} + {1'b0, c_len[acc_idx]};
	assign len_sum = {1'b0, c_len[acc_idx]} + {1'b0, c_len[cand_idx]};
	assign merge_end = (merge_q == count_q);
	assign adjacent = (end_full == {2'b0, c_start[cand_idx]});

	// Odd-even transposition sort: each pass compares disjoint neighbor pairs.
	always_comb begin
		take_prev = '0;
		take_next = '0;
		for (int k = 0; k + 1 < N; k++) begin
			if ((k % 2) == int'(phase_q) && CW'(k + 1) < count_q) begin
				if ((c_start[k+1] != c_start[k]) ? (c_start[k+1] < c_start[k])
						: (c_len[k+1] < c_len[k])) begin
					take_next[k] = 1'b1;
					take_prev[k+1] = 1'b1;
				end
			end
		end
	end

	always_comb begin
		state_d = state_q;
		for (int k = 0; k < N; k++) cell_cmd[k] = CMD_NONE;
		cell_sel = '0;
		wr_start = '0;
		wr_len = '0;
		case (state_q)
			S_IDLE: begin
				if (in_beat) begin
					case (in_op)
						OP_ALLOC: state_d = S_FIND;
						OP_FREE: state_d = (count_q >= CW'(N)) ? S_OUT : S_FREE_POS;
						OP_COALESCE: state_d = (count_q == '0) ? S_OUT : S_SORT;
						default: state_d = S_OUT;
					endcase
				end
			end
			S_FIND: begin
				if (scan_end) begin
					state_d = bump_ok ? S_MUL : S_OUT;
				end else if (scan_fits) begin
					state_d = S_MUL;
					wr_start = scan_start + req_cnt_q[IDX_W-1:0];
					wr_len = scan_rem;
					for (int k = 0; k < N; k++) begin
						if (scan_rem == '0 && PW'(k) >= scan_idx) begin
							cell_cmd[k] = CMD_SHIFT_DOWN;
							cell_sel[k] = 1'b1;
						end else if (scan_rem != '0 && PW'(k) == scan_idx) begin
							cell_cmd[k] = CMD_WRITE;
							cell_sel[k] = 1'b1;
						end
					end
				end
			end
			S_FREE_POS: begin
				if (scan_end || !scan_less) begin
					state_d = S_OUT;
					wr_start = req_off_q;
					wr_len = req_cnt_q;
					for (int k = 0; k < N; k++) begin
						if (PW'(k) == scan_idx) begin
							cell_cmd[k] = CMD_WRITE;
							cell_sel[k] = 1'b1;
						end else if (PW'(k) > scan_idx) begin
							cell_cmd[k] = CMD_SHIFT_UP;
							cell_sel[k] = 1'b1;
						end
					end
				end
			end
			S_SORT: begin
				for (int k = 0; k < N; k++) cell_cmd[k] = CMD_SWAP_PASS;
				if (iter_q == CW'(1)) state_d = S_MERGE;
			end
			S_MERGE: begin
				if (merge_end) begin
					state_d = S_OUT;
				end else if (adjacent) begin
					wr_start = c_start[acc_idx];
					wr_len = len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];
					for (int k = 0; k < N; k++) begin
						if (PW'(k) == acc_idx) begin
							cell_cmd[k] = CMD_WRITE;
							cell_sel[k] = 1'b1;
						end
					end
				end else begin
					wr_start = c_start[cand_idx];
					wr_len = c_len[cand_idx];
					for (int k = 0; k < N; k++) begin
						if (PW'(k) == nxt_idx) begin
							cell_cmd[k] = CMD_WRITE;
							cell_sel[k] = 1'b1;
						end
					end
				end
			end
			S_MUL: state_d = S_OUT;
			S_OUT: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	for (genvar g = 0; g < N; g++) begin : g_cell
		localparam int unsigned GP = (g + N - 1) % N;
		localparam int unsigned GN = (g + 1) % N;
		ffda_cell u_cell (
			.clk(clk),
			.cmd(cell_cmd[g]),
			.sel(cell_sel[g]),
			.wr_start(wr_start),
			.wr_len(wr_len),
			.prev_start(c_start[GP]),
			.prev_len(c_len[GP]),
			.next_start(c_start[GN]),
			.next_len(c_len[GN]),
			.take_prev(take_prev[g]),
			.take_next(take_next[g]),
			.start_q(c_start[g]),
			.len_q(c_len[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= LEN_W'(1048576);
			stride_q <= 13'd32;
			cpu_base_q <= '0;
			gpu_base_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CAPACITY: capacity_q <= cfg_data[LEN_W-1:0];
				REG_STRIDE: stride_q <= cfg_data[12:0];
				REG_CPU_BASE: cpu_base_q <= cfg_data;
				REG_GPU_BASE: gpu_base_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	logic [63:0] off64;
	assign off64 = 64'(prod_q);

	always_comb begin
		out_word = '0;
		out_word[1:0] = status_q;
		if (status_q == ST_OK && op_q == OP_ALLOC) begin
			out_word[2 +: IDX_W] = index_q;
			out_word[2+IDX_W +: 64] = cpu_base_q + off64;
			out_word[2+IDX_W+64 +: 64] = (gpu_base_q != '0) ? gpu_base_q + off64 : 64'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bump_q <= '0;
			count_q <= '0;
			iter_q <= '0;
			pos_q <= '0;
			merge_q <= '0;
			phase_q <= 1'b0;
			op_q <= OP_ALLOC;
			req_cnt_q <= '0;
			req_off_q <= '0;
			status_q <= ST_OK;
			index_q <= '0;
			prod_q <= '0;
			out_data_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						op_q <= in_op;
						req_cnt_q <= s_axis_tdata[2 +: LEN_W];
						req_off_q <= s_axis_tdata[2+LEN_W +: IDX_W];
						status_q <= (in_op == OP_FREE && count_q >= CW'(N)) ? ST_LIST_FULL
							: ST_OK;
						index_q <= '0;
						iter_q <= (in_op == OP_COALESCE) ? count_q : '0;
						phase_q <= 1'b0;
						pos_q <= '0;
						merge_q <= CW'(1);
						if (in_op == OP_RESET_BUMP) bump_q <= '0;
					end
				end
				S_FIND: begin
					if (scan_end) begin
						if (bump_ok) begin
							index_q <= bump_q[IDX_W-1:0];
							bump_q <= bump_sum[LEN_W-1:0];
						end else begin
							status_q <= ST_OVERFLOW;
						end
					end else if (scan_fits) begin
						index_q <= scan_start;
						if (scan_rem == '0) count_q <= count_q - CW'(1);
					end else begin
						iter_q <= iter_q + CW'(1);
					end
				end
				S_FREE_POS: begin
					if (scan_end || !scan_less) begin
						count_q <= count_q + CW'(1);
					end else begin
						iter_q <= iter_q + CW'(1);
					end
				end
				S_SORT: begin
					phase_q <= ~phase_q;
					iter_q <= iter_q - CW'(1);
				end
				S_MERGE: begin
					if (merge_end) begin
						count_q <= pos_q + CW'(1);
					end else begin
						if (!adjacent) pos_q <= pos_q + CW'(1);
						merge_q <= merge_q + CW'(1);
					end
				end
				S_MUL: begin
					prod_q <= MW'(index_q) * MW'(stride_q);
				end
				S_OUT: begin
					if (out_free) out_data_q <= out_word;
				end
				default: begin
				end
			endcase
		end
	end

	`FFDA_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(N))
	`FFDA_ASSERT_IMP(a_iter_bound, clk, arst_n, 1'b1, iter_q <= count_q)
	`FFDA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid_q && !m_axis_tready, out_valid_q && $stable(m_axis_tdata))
	`FFDA_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != S_IDLE, !s_axis_tready)
endmodule

[sim/tb_first_fit_descriptor_allocator.sv]
`timescale 1ns / 1ps
module tb_first_fit_descriptor_allocator;
	import ffda_pkg::*;

	localparam int NBLK = 32;
	localparam int IN_W = ((2 + LEN_W + IDX_W + 7) / 8) * 8;
	localparam int OUT_W = ((2 + IDX_W + 128 + 7) / 8) * 8;
	localparam int WATCHDOG = 20000;

	typedef struct packed {
		logic [1:0] status;
		logic [IDX_W-1:0] slot_index;
		logic [63:0] cpu_handle;
		logic [63:0] gpu_handle;
	} alloc_result_t;

	class alloc_scoreboard;
		logic [LEN_W-1:0] capacity;
		logic [12:0] stride;
		logic [63:0] cpu_base;
		logic [63:0] gpu_base;
		logic [LEN_W-1:0] bump_top;
		int unsigned count;
		logic [IDX_W-1:0] starts[NBLK];
		logic [LEN_W-1:0] lengths[NBLK];
		alloc_result_t pending[$];
		int errors;

		function new();
			capacity = 21'd1048576;
			stride = 13'd32;
			cpu_base = '0;
			gpu_base = '0;
			bump_top = '0;
			count = 0;
			errors = 0;
		endfunction

		function void write_reg(reg_index_t idx, logic [63:0] value);
			case (idx)
				REG_CAPACITY: capacity = value[LEN_W-1:0];
				REG_STRIDE: stride = value[12:0];
				REG_CPU_BASE: cpu_base = value;
				REG_GPU_BASE: gpu_base = value;
				default: begin
				end
			endcase
		endfunction

		function bit key_less(logic [IDX_W-1:0] s1, logic [LEN_W-1:0] l1,
				logic [IDX_W-1:0] s2, logic [LEN_W-1:0] l2);
			if (s1 != s2) return s1 < s2;
			return l1 < l2;
		endfunction

		function alloc_result_t grant(logic [IDX_W-1:0] idx);
			alloc_result_t r;
			logic [63:0] off;
			off = 64'(idx) * 64'(stride);
			r.status = ST_OK;
			r.slot_index = idx;
			r.cpu_handle = cpu_base + off;
			r.gpu_handle = (gpu_base != 0) ? gpu_base + off : 64'd0;
			return r;
		endfunction

		function void note_request(opcode_t op, logic [LEN_W-1:0] cnt,
				logic [IDX_W-1:0] ofs);
			alloc_result_t r;
			int unsigned pos, m;
			int j;
			bit done;
			logic [IDX_W-1:0] s;
			logic [LEN_W-1:0] l;
			logic [LEN_W:0] sum;
			r = '0;
			case (op)
				OP_ALLOC: begin
					done = 0;
					for (int i = 0; i < count && !done; i++) begin
						if (lengths[i] >= cnt) begin
							r = grant(starts[i]);
							starts[i] = starts[i] + IDX_W'(cnt);
							lengths[i] = lengths[i] - cnt;
							if (lengths[i] == 0) begin
								for (int k = i; k + 1 < count; k++) begin
									starts[k] = starts[k+1];
									lengths[k] = lengths[k+1];
								end
								count--;
							end
							done = 1;
						end
					end
					if (!done) begin
						if (22'(bump_top) + 22'(cnt) > 22'(capacity) || bump_top[LEN_W-1])
							r.status = ST_OVERFLOW;
						else begin
							r = grant(bump_top[IDX_W-1:0]);
							bump_top = bump_top + cnt;
						end
					end
				end
				OP_FREE: begin
					if (count >= NBLK) r.status = ST_LIST_FULL;
					else begin
						pos = 0;
						while (pos < count && key_less(starts[pos], lengths[pos], ofs, cnt))
							pos++;
						for (int k = count; k > pos; k--) begin
							starts[k] = starts[k-1];
							lengths[k] = lengths[k-1];
						end
						starts[pos] = ofs;
						lengths[pos] = cnt;
						count++;
					end
				end
				OP_COALESCE: begin
					if (count > 0) begin
						for (int i = 1; i < count; i++) begin
							s = starts[i];
							l = lengths[i];
							j = i;
							while (j > 0 && key_less(s, l, starts[j-1], lengths[j-1])) begin
								starts[j] = starts[j-1];
								lengths[j] = lengths[j-1];
								j--;
							end
							starts[j] = s;
							lengths[j] = l;
						end
						m = 0;
						for (int i = 1; i < count; i++) begin
							if (22'(starts[m]) + 22'(lengths[m]) == 22'(starts[i])) begin
								sum = 22'(lengths[m]) + 22'(lengths[i]);
								lengths[m] = sum[LEN_W] ? LEN_MAX : sum[LEN_W-1:0];
							end else begin
								m++;
								starts[m] = starts[i];
								lengths[m] = lengths[i];
							end
						end
						count = m + 1;
					end
				end
				default: bump_top = '0;
			endcase
			pending = {pending, r};
		endfunction

		function void check_result(logic [OUT_W-1:0] data);
			alloc_result_t e;
			logic [1:0] st;
			logic [IDX_W-1:0] idx;
			logic [63:0] ch, gh;
			st = data[1:0];
			idx = data[2 +: IDX_W];
			ch = data[2 + IDX_W +: 64];
			gh = data[2 + IDX_W + 64 +: 64];
			if (pending.size() == 0) begin
				$error("unexpected result beat %h", data);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (st !== e.status) begin
				$error("status expected %0d actual %0d", e.status, st);
				errors++;
			end
			if (idx !== e.slot_index) begin
				$error("slot_index expected %0d actual %0d", e.slot_index, idx);
				errors++;
			end
			if (ch !== e.cpu_handle) begin
				$error("cpu_handle expected %h actual %h", e.cpu_handle, ch);
				errors++;
			end
			if (gh !== e.gpu_handle) begin
				$error("gpu_handle expected %h actual %h", e.gpu_handle, gh);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [63:0] cfg_data;

	alloc_scoreboard board;
	int idle_cycles;
	bit stim_done;

	first_fit_descriptor_allocator dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// The valid stays high after a beat; the next call either replaces the data or drops it.
	task automatic send_request(opcode_t op, logic [LEN_W-1:0] cnt, logic [IDX_W-1:0] ofs);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_W'({ofs, cnt, op});
		do @(posedge clk); while (!s_axis_tready);
		board.note_request(op, cnt, ofs);
	endtask

	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, value);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_request(int unsigned cap);
		int unsigned sel;
		logic [LEN_W-1:0] cnt;
		sel = $urandom_range(0, 99);
		cnt = ($urandom_range(0, 19) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(0, cap));
		if (sel < 45) send_request(OP_ALLOC, cnt, '0);
		else if (sel < 85) send_request(OP_FREE, cnt, IDX_W'($urandom));
		else if (sel < 95) send_request(OP_COALESCE, LEN_W'($urandom), IDX_W'($urandom));
		else send_request(OP_RESET_BUMP, LEN_W'($urandom), IDX_W'($urandom));
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)
					|| (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		int gap;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 3);
			if (stim_done || $urandom_range(0, 3) == 0) gap = 0;
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	initial begin
		board = new();
		idle_cycles = 0;
		stim_done = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_CAPACITY;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(OP_ALLOC, 21'd0, '0);
		send_request(OP_ALLOC, 21'd16, '0);
		send_request(OP_ALLOC, 21'h1FFFFF, '0);
		send_request(OP_FREE, 21'd4, 20'd100);
		send_request(OP_FREE, 21'd0, 20'd50);
		send_request(OP_FREE, 21'd4, 20'd104);
		send_request(OP_FREE, 21'h1FFFFF, 20'hFFFFF);
		send_request(OP_FREE, 21'h100000, 20'hFFFFF);
		send_request(OP_ALLOC, 21'd0, '0);
		send_request(OP_COALESCE, '0, '0);
		send_request(OP_ALLOC, 21'd8, '0);
		send_request(OP_ALLOC, 21'h1FFFFF, '0);
		send_request(OP_ALLOC, 21'd3, '0);
		send_request(OP_RESET_BUMP, '1, '1);
		for (int i = 0; i < 34; i++) send_request(OP_FREE, 21'd1, IDX_W'(i * 2));
		send_request(OP_COALESCE, '0, '0);
		wait_drain();

		write_reg(REG_CAPACITY, 64'd0);
		write_reg(REG_STRIDE, 64'd4096);
		write_reg(REG_CPU_BASE, '1);
		write_reg(REG_GPU_BASE, 64'h8000_0000_0000_0000);
		send_request(OP_COALESCE, '0, '0);
		send_request(OP_ALLOC, 21'd0, '0);
		send_request(OP_ALLOC, 21'd1, '0);

		for (int ph = 0; ph < 5; ph++) begin
			wait_drain();
			case (ph)
				0: begin
					write_reg(REG_CAPACITY, 64'd1048576);
					write_reg(REG_STRIDE, 64'd0);
					write_reg(REG_GPU_BASE, 64'd0);
				end
				1: begin
					write_reg(REG_CAPACITY, 64'h1FFFFF);
					write_reg(REG_STRIDE, 64'h1FFF);
					write_reg(REG_CPU_BASE, {$urandom, $urandom});
					write_reg(REG_GPU_BASE, {$urandom, $urandom});
				end
				2: begin
					write_reg(REG_CAPACITY, 64'd200);
					write_reg(REG_STRIDE, 64'd1);
				end
				3: begin
					write_reg(REG_CAPACITY, {$urandom, $urandom});
					write_reg(REG_STRIDE, 64'd32);
					write_reg(REG_CPU_BASE, 64'd0);
				end
				default: write_reg(REG_GPU_BASE, '1);
			endcase
			for (int i = 0; i < 190; i++)
				random_request((ph == 2) ? 40 : ((i % 3 == 0) ? 1048576 : 64));
		end
		stim_done = 1;
		wait_drain();
		if (board.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

[sim.f]
+incdir+hdl
hdl/ffda_pkg.sv
hdl/ffda_cell.sv
hdl/first_fit_descriptor_allocator.sv
sim/tb_first_fit_descriptor_allocator.sv
